// File: rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg - colour wheel pixel generator shared definitions
// Types, codes and reset values used by the colour wheel datapath and top.
// ----------------------------------------------------------------------------
package rcw_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned ROW_W   = 5;
    localparam int unsigned COL_W   = 4;
    localparam int unsigned PAT_W   = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
    localparam logic [CHAN_W-1:0] CHAN_MIN = 8'd0;

    // request codes
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // pattern codes
    localparam logic [PAT_W-1:0] PAT_UNIFORM = 2'd0;
    localparam logic [PAT_W-1:0] PAT_CASCADE = 2'd1;
    localparam logic [PAT_W-1:0] PAT_SINGLE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN   = 1'b1;

    localparam logic [CHAN_W-1:0] STEP_RESET    = 8'd10;
    localparam logic [PAT_W-1:0]  PATTERN_RESET = PAT_UNIFORM;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_color;

    localparam t_color COLOR_RESET = '{red: 8'd128, green: 8'd255, blue: 8'd0};

    typedef struct packed {
        logic             req_type;
        logic             in_matrix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_req;

    typedef struct packed {
        t_color           color;
        logic             write_pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_result;

endpackage

// File: rtl/rcw_wheel_step.sv
// ----------------------------------------------------------------------------
// rcw_wheel_step - one colour wheel step
// Applies the first matching edge rule, moving one channel by the step with
// saturation at full scale or zero.
// ----------------------------------------------------------------------------
module rcw_wheel_step
    import rcw_pkg::*;
(
    input  t_color            i_color,
    input  logic [CHAN_W-1:0] i_step,
    output t_color            o_color
);

    logic [CHAN_W:0] up_red, up_green, up_blue;
    logic [CHAN_W-1:0] sat_up_red, sat_up_green, sat_up_blue;
    logic [CHAN_W-1:0] sat_dn_red, sat_dn_green, sat_dn_blue;

    assign up_red   = {1'b0, i_color.red}   + {1'b0, i_step};
    assign up_green = {1'b0, i_color.green} + {1'b0, i_step};
    assign up_blue  = {1'b0, i_color.blue}  + {1'b0, i_step};

    assign sat_up_red   = up_red[CHAN_W]   ? CHAN_MAX : up_red[CHAN_W-1:0];
    assign sat_up_green = up_green[CHAN_W] ? CHAN_MAX : up_green[CHAN_W-1:0];
    assign sat_up_blue  = up_blue[CHAN_W]  ? CHAN_MAX : up_blue[CHAN_W-1:0];

    assign sat_dn_red   = (i_color.red > i_step)   ? i_color.red - i_step   : CHAN_MIN;
    assign sat_dn_green = (i_color.green > i_step) ? i_color.green - i_step : CHAN_MIN;
    assign sat_dn_blue  = (i_color.blue > i_step)  ? i_color.blue - i_step  : CHAN_MIN;

    // rules are tried in order, first match wins
    always_comb begin
        o_color = i_color;
        priority if (i_color.blue == CHAN_MAX && i_color.green == CHAN_MIN
                     && i_color.red != CHAN_MAX) begin
            o_color.red = sat_up_red;
        end else if (i_color.green == CHAN_MAX && i_color.red != CHAN_MIN
                     && i_color.blue == CHAN_MIN) begin
            o_color.red = sat_dn_red;
        end else if (i_color.red == CHAN_MAX && i_color.blue == CHAN_MIN
                     && i_color.green != CHAN_MAX) begin
            o_color.green = sat_up_green;
        end else if (i_color.blue == CHAN_MAX && i_color.green != CHAN_MIN
                     && i_color.red == CHAN_MIN) begin
            o_color.green = sat_dn_green;
        end else if (i_color.green == CHAN_MAX && i_color.red == CHAN_MIN
                     && i_color.blue != CHAN_MAX) begin
            o_color.blue = sat_up_blue;
        end else if (i_color.red == CHAN_MAX && i_color.blue != CHAN_MIN
                     && i_color.green == CHAN_MIN) begin
            o_color.blue = sat_dn_blue;
        end else begin
            o_color = i_color;
        end
    end

endmodule

// File: rtl/rcw_core.sv
// ----------------------------------------------------------------------------
// rcw_core - colour state and result selection
// Holds the base and working colours and forms one result per request.
// ----------------------------------------------------------------------------
module rcw_core
    import rcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_req              i_req,
    input  logic [CHAN_W-1:0] i_step_size,
    input  logic [PAT_W-1:0]  i_pattern,
    output t_result           o_result
);

    t_color r_base, n_base;
    t_color r_work, n_work;
    t_color base_step, base_step2, work_step;
    t_color sel_color;
    logic   sel_write;

    rcw_wheel_step u_base_step (
        .i_color (r_base),
        .i_step  (i_step_size),
        .o_color (base_step)
    );

    // frame write in single-pixel mode shows the new base stepped once more
    rcw_wheel_step u_base_step2 (
        .i_color (base_step),
        .i_step  (i_step_size),
        .o_color (base_step2)
    );

    rcw_wheel_step u_work_step (
        .i_color (r_work),
        .i_step  (i_step_size),
        .o_color (work_step)
    );

    always_comb begin
        n_base    = r_base;
        n_work    = r_work;
        sel_color = r_base;
        sel_write = 1'b0;
        if (i_req.req_type == REQ_FRAME) begin
            n_base    = base_step;
            n_work    = base_step;
            sel_color = base_step2;
            sel_write = (i_pattern == PAT_SINGLE) && i_req.in_matrix;
        end else if (i_req.in_matrix) begin
            if (i_pattern == PAT_UNIFORM) begin
                sel_write = 1'b1;
            end else if (i_pattern == PAT_CASCADE) begin
                n_work    = work_step;
                sel_color = work_step;
                sel_write = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= COLOR_RESET;
            r_work <= COLOR_RESET;
        end else if (i_accept) begin
            r_base <= n_base;
            r_work <= n_work;
        end
    end

    // drop every field of a result that writes nothing
    always_comb begin
        o_result = '0;
        if (sel_write) begin
            o_result.color       = sel_color;
            o_result.write_pixel = 1'b1;
            o_result.row         = i_req.row;
            o_result.col         = i_req.col;
        end
    end

endmodule

// File: rtl/rainbow_color_wheel_pixel_generator.sv
// ----------------------------------------------------------------------------
// rainbow_color_wheel_pixel_generator - LED matrix colour wheel generator
// Frame and pixel requests in, one pixel write result out per request.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------------
//   request  | i_in_valid / o_in_stall | i_req_type, i_pixel_row, i_pixel_col
//   result   | o_out_valid/i_out_stall | o_red_out .. o_col_out
//   config   | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One request per cycle unless stalled; its result is in the output register
// on the next cycle. The step, up to two chained wheel steps, is combinational.
// Synchronous active-low reset restores the start colour, step 10, uniform.
// Requests are stalled only while a result is held and the sink stalls.
// ----------------------------------------------------------------------------
module rainbow_color_wheel_pixel_generator
    import rcw_pkg::*;
#(
    parameter int ROWS = 20,
    parameter int COLS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [ROW_W-1:0]      i_pixel_row,
    input  logic [COL_W-1:0]      i_pixel_col,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAN_W-1:0]     o_red_out,
    output logic [CHAN_W-1:0]     o_green_out,
    output logic [CHAN_W-1:0]     o_blue_out,
    output logic                  o_write_pixel,
    output logic [ROW_W-1:0]      o_row_out,
    output logic [COL_W-1:0]      o_col_out
);

    logic [CHAN_W-1:0] r_step_size;
    logic [PAT_W-1:0]  r_pattern;
    logic              r_out_valid;
    t_result           r_out, n_out;
    t_req              req;
    logic              in_xfer;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign req.req_type  = i_req_type;
    assign req.in_matrix = (32'(i_pixel_row) < 32'(ROWS)) && (32'(i_pixel_col) < 32'(COLS));
    assign req.row       = i_pixel_row;
    assign req.col       = i_pixel_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= STEP_RESET;
            r_pattern   <= PATTERN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEP_SIZE: r_step_size <= i_cfg_data;
                CFG_PATTERN:   r_pattern   <= i_cfg_data[PAT_W-1:0];
                default:       r_step_size <= r_step_size;
            endcase
        end
    end

    rcw_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_req       (req),
        .i_step_size (r_step_size),
        .i_pattern   (r_pattern),
        .o_result    (n_out)
    );

    // hold the result until the sink takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_red_out     = r_out.color.red;
    assign o_green_out   = r_out.color.green;
    assign o_blue_out    = r_out.color.blue;
    assign o_write_pixel = r_out.write_pixel;
    assign o_row_out     = r_out.row;
    assign o_col_out     = r_out.col;

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_out_valid)
        else $error("accepted request produced no result");

    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_pixel) |->
        (o_red_out == '0 && o_green_out == '0 && o_blue_out == '0
         && o_row_out == '0 && o_col_out == '0))
        else $error("non-writing result carries non-zero fields");

    a_write_in_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_pixel) |->
        (32'(o_row_out) < 32'(ROWS) && 32'(o_col_out) < 32'(COLS)))
        else $error("pixel write outside the matrix");

    a_frame_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_req_type == REQ_FRAME && r_pattern != PAT_SINGLE)
        |=> !o_write_pixel)
        else $error("frame request wrote a pixel outside single-pixel mode");
`endif

endmodule
